// ===== src/ept_pkg.sv =====
// Shared constants, codes and types for the envelope-triggered pitch shifter.
package ept_pkg;

    localparam int DELAY_DEPTH = 8192;
    localparam int DELAY_AW    = $clog2(DELAY_DEPTH);
    localparam int BASE_DELAY  = 64;
    localparam int WIN_DEPTH   = 1024;
    localparam int WIN_AW      = $clog2(WIN_DEPTH);
    localparam int WIN_W       = 17;

    localparam int SAMPLE_W  = 16;
    localparam int RATIO_W   = 17;
    localparam int COEF_W    = 16;
    localparam int GRAIN_W   = 13;
    localparam int PHASE_W   = 32;
    localparam int CFG_W     = 17;
    localparam int CFG_IDX_W = 3;

    localparam int GRAIN_MIN  = 64;
    localparam int GRAIN_MAX  = 4096;
    localparam int RATIO_UNIT = 16384;

    localparam int DIV_NUM_W = 35;
    localparam int DIV_DEN_W = GRAIN_W;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ENABLE,
        REG_TARGET_RATIO,
        REG_TRIGGER_LEVEL,
        REG_ENVELOPE_RELEASE,
        REG_GLIDE_ATTACK,
        REG_GLIDE_RELEASE,
        REG_GRAIN_LENGTH
    } cfg_reg_t;

    typedef enum logic [4:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_ENV_MUL,
        ST_ENV_SUM,
        ST_RAT_MUL,
        ST_RAT_SUM,
        ST_DIV_START,
        ST_TAP_POS,
        ST_TAP_ADDR,
        ST_TAP_READ,
        ST_HERM_A,
        ST_HERM_B,
        ST_HERM_C,
        ST_HERM_D,
        ST_ACCUM,
        ST_FINISH,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic                 start;
        logic [DIV_NUM_W-1:0] dividend;
        logic [DIV_DEN_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic                 done;
        logic [DIV_NUM_W-1:0] quotient;
    } div_rsp_t;

endpackage

// ===== src/ept_in_if.sv =====
// Input sample channel.
interface ept_in_if import ept_pkg::*;;
    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] sample_in;

    modport source (output valid, output sample_in, input ready);
    modport sink   (input valid, input sample_in, output ready);
endinterface

// ===== src/ept_out_if.sv =====
// Output sample channel.
interface ept_out_if import ept_pkg::*;;
    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] sample_out;

    modport source (output valid, output sample_out, input ready);
    modport sink   (input valid, input sample_out, output ready);
endinterface

// ===== src/ept_ram.sv =====
// Generic simple dual-port RAM with registered read.
module ept_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end
endmodule

// ===== src/ept_div.sv =====
// Restoring unsigned divider, one quotient bit per cycle.
module ept_div import ept_pkg::*; (
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);
    localparam int CNT_W = $clog2(DIV_NUM_W + 1);

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic [DIV_NUM_W-1:0] num_reg, num_next;
    logic [DIV_DEN_W-1:0] rem_reg, rem_next;
    logic [DIV_DEN_W-1:0] den_reg, den_next;
    logic [DIV_DEN_W:0]   trial;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = done_reg;
        cnt_next  = cnt_reg;
        num_next  = num_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        trial     = {rem_reg, num_reg[DIV_NUM_W-1]};
        if (req.start)
        begin
            busy_next = 1'b1;
            done_next = 1'b0;
            cnt_next  = '0;
            num_next  = req.dividend;
            rem_next  = '0;
            den_next  = req.divisor;
        end
        else if (busy_reg)
        begin
            // trial stays below twice the divisor, so the remainder fits
            if (trial >= {1'b0, den_reg})
            begin
                rem_next = DIV_DEN_W'(trial - {1'b0, den_reg});
                num_next = {num_reg[DIV_NUM_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[DIV_DEN_W-1:0];
                num_next = {num_reg[DIV_NUM_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(DIV_NUM_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = num_reg;
endmodule

// ===== src/envelope_triggered_pitch_shifter_core.sv =====
// Top level of the envelope-triggered granular pitch shifter.
//
//  channel  | dir | transfer when       | payload
//  ---------+-----+---------------------+---------------------------
//  din      | in  | valid && ready      | sample_in  (s16, Q1.15)
//  dout     | out | valid && ready      | sample_out (s16, Q1.15)
//  config   | in  | write_enable        | reg_index, write_data
//
// Enabled sample: envelope update, glide update, divider start, two tap reads
// with Hermite interpolation, then the output load; din.ready rises again
// together with dout.valid. The 35-step grain divider sets the pace: it starts
// after the glide update, overlapping the two tap reads, and ST_FINISH waits for it.
// Disabled sample: passed through unchanged via ST_DONE into the output register,
// and the next sample is taken once the block is back in ST_IDLE.
// After reset a clearing pass over all DELAY_DEPTH (8192) addresses zeroes the delay
// RAM and loads the window RAM; din.ready stays low meanwhile.
// A finished result sits in the output register; the next sample is taken
// while it waits, and the block stalls only before loading a second result.
module envelope_triggered_pitch_shifter_core import ept_pkg::*; (
    input  logic                 clk,
    input  logic                 rst_n,
    ept_in_if.sink               din,
    ept_out_if.source            dout,
    input  logic                 write_enable,
    input  logic [CFG_IDX_W-1:0] reg_index,
    input  logic [CFG_W-1:0]     write_data
);
    // ---------------- configuration registers ----------------
    logic               enable_reg;
    logic [RATIO_W-1:0] target_ratio_reg;
    logic [15:0]        trigger_level_reg;
    logic [COEF_W-1:0]  env_release_reg;
    logic [COEF_W-1:0]  glide_attack_reg;
    logic [COEF_W-1:0]  glide_release_reg;
    logic [GRAIN_W-1:0] grain_length_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg        <= 1'b0;
            target_ratio_reg  <= RATIO_W'(32768);
            trigger_level_reg <= 16'd3277;
            env_release_reg   <= 16'd65446;
            glide_attack_reg  <= 16'd65388;
            glide_release_reg <= 16'd65388;
            grain_length_reg  <= GRAIN_W'(2117);
        end
        else if (write_enable)
        begin
            unique case (cfg_reg_t'(reg_index))
                REG_ENABLE:           enable_reg        <= write_data[0];
                REG_TARGET_RATIO:     target_ratio_reg  <= write_data[RATIO_W-1:0];
                REG_TRIGGER_LEVEL:    trigger_level_reg <= write_data[15:0];
                REG_ENVELOPE_RELEASE: env_release_reg   <= write_data[COEF_W-1:0];
                REG_GLIDE_ATTACK:     glide_attack_reg  <= write_data[COEF_W-1:0];
                REG_GLIDE_RELEASE:    glide_release_reg <= write_data[COEF_W-1:0];
                REG_GRAIN_LENGTH:     grain_length_reg  <= write_data[GRAIN_W-1:0];
                default:              ;
            endcase
        end
    end

    // ---------------- window table (elaborated constants) ----------------
    // entry k ~ sin^2(pi k/D) via the rational sine approximation
    logic [WIN_W-1:0] win_rom [WIN_DEPTH];

    for (genvar k = 0; k < WIN_DEPTH; k++)
    begin : g_win
        localparam longint unsigned WD = WIN_DEPTH;
        localparam longint unsigned KK = k;
        localparam longint unsigned Q  = ((KK * (WD - KK)) << 16) / (WD * WD);
        localparam longint unsigned S  = ((64'd16 * Q) << 16) / (64'd327680 - 64'd4 * Q);
        localparam longint unsigned E  = (S * S + 64'd32768) >> 16;
        assign win_rom[k] = WIN_W'(E);
    end

    // ---------------- state ----------------
    state_t state_reg, state_next;

    logic [DELAY_AW-1:0]        clr_cnt_reg;
    logic [DELAY_AW-1:0]        wr_idx_reg;
    logic [15:0]                env_reg;
    logic [RATIO_W-1:0]         ratio_reg;
    logic [PHASE_W-1:0]         phase_reg;

    logic signed [SAMPLE_W-1:0] sample_reg;
    logic signed [SAMPLE_W-1:0] res_reg;
    logic                       out_valid_reg;
    logic signed [SAMPLE_W-1:0] out_data_reg;

    logic [31:0]                env_p1_reg;
    logic [32:0]                env_p2_reg;
    logic [32:0]                rat_p1_reg;
    logic [33:0]                rat_p2_reg;
    logic                       inc_neg_reg;
    logic                       tap_sel_reg;
    logic [44:0]                off_reg;
    logic [WIN_W-1:0]           win_reg;
    logic [DELAY_AW-1:0]        base_reg;
    logic [15:0]                frac_reg;
    logic [2:0]                 rd_cnt_reg;
    logic signed [SAMPLE_W-1:0] x_reg [4];
    logic signed [47:0]         prod_reg;
    logic signed [47:0]         acc_reg;

    // ---------------- memories ----------------
    logic                  dly_we, dly_re;
    logic [DELAY_AW-1:0]   dly_waddr, dly_raddr;
    logic [SAMPLE_W-1:0]   dly_wdata, dly_rdata;
    logic                  win_we, win_re;
    logic [WIN_AW-1:0]     win_waddr, win_raddr;
    logic [WIN_W-1:0]      win_rdata;

    ept_ram #(.WIDTH(SAMPLE_W), .DEPTH(DELAY_DEPTH)) u_delay_ram (
        .clk   (clk),
        .we    (dly_we),
        .waddr (dly_waddr),
        .wdata (dly_wdata),
        .re    (dly_re),
        .raddr (dly_raddr),
        .rdata (dly_rdata)
    );

    ept_ram #(.WIDTH(WIN_W), .DEPTH(WIN_DEPTH)) u_win_ram (
        .clk   (clk),
        .we    (win_we),
        .waddr (win_waddr),
        .wdata (win_rom[win_waddr]),
        .re    (win_re),
        .raddr (win_raddr),
        .rdata (win_rdata)
    );

    // ---------------- divider for the phase increment ----------------
    div_req_t div_req;
    div_rsp_t div_rsp;

    ept_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // ---------------- combinational datapath ----------------
    logic [GRAIN_W-1:0]  grain;
    logic [15:0]         mag;
    logic                triggered;
    logic [RATIO_W-1:0]  glide_tgt;
    logic [COEF_W-1:0]   glide_coef;
    logic signed [18:0]  ratio_diff;
    logic [18:0]         diff_mag;
    logic [PHASE_W-1:0]  tap_phase;
    logic [63:0]         tap_pos;
    logic [31:0]         inc;
    logic signed [21:0]  c2, v, w2, a2, b2;
    logic signed [16:0]  f_s;
    logic signed [25:0]  p_b, p_c, h_d;
    logic signed [47:0]  y_sum, y_shift;
    logic signed [SAMPLE_W-1:0] y_sat;
    logic                load_out;

    always_comb
    begin
        if (grain_length_reg < GRAIN_W'(GRAIN_MIN))
        begin
            grain = GRAIN_W'(GRAIN_MIN);
        end
        else if (grain_length_reg > GRAIN_W'(GRAIN_MAX))
        begin
            grain = GRAIN_W'(GRAIN_MAX);
        end
        else
        begin
            grain = grain_length_reg;
        end
    end

    assign mag        = sample_reg[SAMPLE_W-1] ? 16'(~sample_reg + 1'b1) : 16'(sample_reg);
    assign triggered  = env_reg > trigger_level_reg;
    assign glide_tgt  = triggered ? target_ratio_reg : RATIO_W'(RATIO_UNIT);
    assign glide_coef = triggered ? glide_attack_reg : glide_release_reg;
    assign ratio_diff = 19'(RATIO_UNIT) - {2'b00, ratio_reg};
    assign diff_mag   = ratio_diff[18] ? 19'(-ratio_diff) : 19'(ratio_diff);
    assign tap_phase  = phase_reg + {tap_sel_reg, 31'b0};
    assign tap_pos    = {32'(wr_idx_reg) + 32'(DELAY_DEPTH - BASE_DELAY), 32'b0}
                        - 64'(off_reg);
    assign inc        = inc_neg_reg ? 32'(-div_rsp.quotient[31:0])
                                    : div_rsp.quotient[31:0];

    // Hermite coefficients, doubled
    assign c2  = 22'(x_reg[2]) - 22'(x_reg[0]);
    assign v   = 22'(x_reg[1]) - 22'(x_reg[2]);
    assign w2  = c2 + (v <<< 1);
    assign a2  = w2 + (v <<< 1) + (22'(x_reg[3]) - 22'(x_reg[1]));
    assign b2  = w2 + a2;
    assign f_s = {1'b0, frac_reg};
    assign p_b = 26'(prod_reg >>> 16) - 26'(b2);
    assign p_c = 26'(prod_reg >>> 16) + 26'(c2);
    assign h_d = 26'(prod_reg >>> 16) + (26'(x_reg[1]) <<< 1);

    assign y_sum   = acc_reg + 48'sd65536;
    assign y_shift = y_sum >>> 17;

    always_comb
    begin
        if (y_shift > 48'sd32767)
        begin
            y_sat = 16'sd32767;
        end
        else if (y_shift < -48'sd32767)
        begin
            y_sat = -16'sd32767;
        end
        else
        begin
            y_sat = 16'(y_shift);
        end
    end

    // ---------------- next state ----------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (clr_cnt_reg == DELAY_AW'(DELAY_DEPTH - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (din.valid)
                begin
                    state_next = enable_reg ? ST_ENV_MUL : ST_DONE;
                end
            end
            ST_ENV_MUL:   state_next = ST_ENV_SUM;
            ST_ENV_SUM:   state_next = ST_RAT_MUL;
            ST_RAT_MUL:   state_next = ST_RAT_SUM;
            ST_RAT_SUM:   state_next = ST_DIV_START;
            ST_DIV_START: state_next = ST_TAP_POS;
            ST_TAP_POS:   state_next = ST_TAP_ADDR;
            ST_TAP_ADDR:  state_next = ST_TAP_READ;
            ST_TAP_READ:
            begin
                if (rd_cnt_reg == 3'd4)
                begin
                    state_next = ST_HERM_A;
                end
            end
            ST_HERM_A:    state_next = ST_HERM_B;
            ST_HERM_B:    state_next = ST_HERM_C;
            ST_HERM_C:    state_next = ST_HERM_D;
            ST_HERM_D:    state_next = ST_ACCUM;
            ST_ACCUM:     state_next = tap_sel_reg ? ST_FINISH : ST_TAP_POS;
            ST_FINISH:
            begin
                if (div_rsp.done)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || dout.ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:      state_next = ST_IDLE;
        endcase
    end

    // ---------------- control outputs ----------------
    always_comb
    begin
        din.ready        = 1'b0;
        dly_we           = 1'b0;
        dly_waddr        = wr_idx_reg;
        dly_wdata        = sample_reg;
        dly_re           = 1'b0;
        dly_raddr        = base_reg + DELAY_AW'(rd_cnt_reg[1:0]);
        win_we           = 1'b0;
        win_waddr        = clr_cnt_reg[WIN_AW-1:0];
        win_re           = 1'b0;
        win_raddr        = tap_phase[PHASE_W-1 -: WIN_AW];
        div_req.start    = 1'b0;
        div_req.dividend = {diff_mag[16:0], 18'b0};
        div_req.divisor  = grain;
        load_out         = 1'b0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                dly_we    = 1'b1;
                dly_waddr = clr_cnt_reg;
                dly_wdata = '0;
                win_we    = (32'(clr_cnt_reg) < 32'(WIN_DEPTH));
            end
            ST_IDLE:      din.ready = 1'b1;
            ST_ENV_MUL:   dly_we = 1'b1;
            ST_DIV_START: div_req.start = 1'b1;
            ST_TAP_POS:   win_re = 1'b1;
            ST_TAP_READ:  dly_re = (rd_cnt_reg != 3'd4);
            ST_DONE:      load_out = !out_valid_reg || dout.ready;
            default:      ;
        endcase
    end

    // ---------------- registers ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_cnt_reg   <= '0;
            wr_idx_reg    <= '0;
            env_reg       <= '0;
            ratio_reg     <= RATIO_W'(RATIO_UNIT);
            phase_reg     <= '0;
            out_valid_reg <= 1'b0;
            tap_sel_reg   <= 1'b0;
            rd_cnt_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (dout.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_CLEAR:     clr_cnt_reg <= clr_cnt_reg + 1'b1;
                ST_ENV_SUM:
                begin
                    if (mag > env_reg)
                    begin
                        env_reg <= mag;
                    end
                    else
                    begin
                        env_reg <= 16'((34'(env_p1_reg) + 34'(env_p2_reg) + 34'd32768) >> 16);
                    end
                end
                ST_RAT_SUM:
                begin
                    ratio_reg <= RATIO_W'((35'(rat_p1_reg) + 35'(rat_p2_reg)
                                           + 35'd32768) >> 16);
                end
                ST_DIV_START: tap_sel_reg <= 1'b0;
                ST_TAP_ADDR:  rd_cnt_reg <= '0;
                ST_TAP_READ:  rd_cnt_reg <= rd_cnt_reg + 1'b1;
                ST_ACCUM:     tap_sel_reg <= 1'b1;
                ST_FINISH:
                begin
                    if (div_rsp.done)
                    begin
                        phase_reg  <= phase_reg + inc;
                        wr_idx_reg <= wr_idx_reg + 1'b1;
                    end
                end
                default:      ;
            endcase
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            out_data_reg <= res_reg;
        end
        unique case (state_reg)
            ST_IDLE:
            begin
                sample_reg <= din.sample_in;
                res_reg    <= din.sample_in;
            end
            ST_ENV_MUL:
            begin
                env_p1_reg <= env_reg * env_release_reg;
                env_p2_reg <= 33'(mag) * (33'd65536 - 33'(env_release_reg));
            end
            ST_RAT_MUL:
            begin
                rat_p1_reg <= 33'(ratio_reg) * 33'(glide_coef);
                rat_p2_reg <= 34'(glide_tgt) * (34'd65536 - 34'(glide_coef));
            end
            ST_DIV_START:
            begin
                inc_neg_reg <= ratio_diff[18];
                acc_reg     <= '0;
            end
            ST_TAP_POS:   off_reg <= 45'(tap_phase) * 45'(grain);
            ST_TAP_ADDR:
            begin
                win_reg  <= win_rdata;
                base_reg <= tap_pos[32 +: DELAY_AW] - 1'b1;
                frac_reg <= tap_pos[31:16];
            end
            ST_TAP_READ:
            begin
                if (rd_cnt_reg != 3'd0)
                begin
                    x_reg[2'(rd_cnt_reg - 3'd1)] <= dly_rdata;
                end
            end
            ST_HERM_A:    prod_reg <= 48'(a2 * f_s);
            ST_HERM_B:    prod_reg <= 48'(p_b * f_s);
            ST_HERM_C:    prod_reg <= 48'(p_c * f_s);
            ST_HERM_D:    prod_reg <= 48'($signed({1'b0, win_reg}) * h_d);
            ST_ACCUM:     acc_reg <= acc_reg + prod_reg;
            ST_FINISH:    res_reg <= y_sat;
            default:      ;
        endcase
    end

    assign dout.valid      = out_valid_reg;
    assign dout.sample_out = out_data_reg;
endmodule
